[hw/rtl/ewht_pkg.sv]
// ----------------------------------------------------------------------------
// ewht_pkg - shared constants for the energy walker histogram tracker
// Field widths, register indexes and sequencer state codes.
// ----------------------------------------------------------------------------
package ewht_pkg;

    localparam int LVL_W  = 8;   // energy, bin and level fields
    localparam int NB_W   = 16;  // moves per iteration
    localparam int OUT_W  = 32;  // reported counters
    localparam int ITER_W = 32;  // iteration counter

    // configuration register indexes
    localparam logic CFG_MAX_ENTROPY = 1'b0;
    localparam logic CFG_NUM_BALLS   = 1'b1;

    // input operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;

endpackage

[hw/rtl/energy_walker_histogram_tracker.sv]
// ----------------------------------------------------------------------------
// energy_walker_histogram_tracker - walker and histogram bookkeeping
// Per-level counters for a flat-histogram Monte Carlo run, kept in one
// synchronous row memory with read-modify-write per move.
// ----------------------------------------------------------------------------
// Each input word either records one move (op = 0) or reads one bin (op = 1)
// and returns exactly one result word. All per-level state (visit, upward
// walker, total walker and sample counters plus the observed mark) lives in
// one row memory of LEVELS entries with a registered read. For a plain
// item the accept cycle issues the row read; ST_UPD then, once the result
// register is free, modifies and writes the row back and loads the result
// register, which then waits for the consumer while the next word can
// already be accepted. A recorded change that clears a range (observed
// marks or upward walkers from max_entropy_level to the top level) walks
// that range one row per cycle, then passes ST_DRAIN and ST_RD. After
// reset a clearing pass over all LEVELS rows zeroes the memory; no input
// word is taken during it, configuration writes are. Counters saturate.
// ----------------------------------------------------------------------------
module energy_walker_histogram_tracker
    import ewht_pkg::*;
#(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [NB_W-1:0]      cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [LVL_W-1:0]     s_energy,
    input  logic                 s_changed,
    input  logic [LVL_W-1:0]     s_bin,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LVL_W-1:0]     m_min_energy_level,
    output logic [OUT_W-1:0]     m_iterations,
    output logic [OUT_W-1:0]     m_visit_count,
    output logic [OUT_W-1:0]     m_up_count,
    output logic [OUT_W-1:0]     m_walker_count,
    output logic [OUT_W-1:0]     m_sample_count,
    output logic                 m_observed_flag
);

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int XW = (LW > LVL_W) ? LW : LVL_W;
    localparam int CB = COUNT_BITS;
    localparam int RW = 4 * CB + 1;
    // row layout: visit | up | all | sample | observed
    localparam int SMP_LO = 1;
    localparam int ALL_LO = CB + 1;
    localparam int UP_LO  = 2 * CB + 1;
    localparam int VIS_LO = 3 * CB + 1;

    localparam logic [XW:0]   LEVELS_X = (XW + 1)'(LEVELS);
    localparam logic [LW-1:0] TOP_IDX  = LW'(LEVELS - 1);

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == {CB{1'b1}}) ? v : v + CB'(1);
    endfunction

    function automatic logic [OUT_W-1:0] clip_out(input logic [CB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (|w[63:OUT_W]) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LVL_W-1:0] mer_reg;
    logic [NB_W-1:0]  nb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mer_reg <= '0;
            nb_reg  <= NB_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_ENTROPY: mer_reg <= cfg_wdata[LVL_W-1:0];
                CFG_NUM_BALLS:   nb_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Row memory
    // ------------------------------------------------------------------
    logic [RW-1:0]  mem [LEVELS];
    logic           mem_we;
    logic [LW-1:0]  mem_wa;
    logic [RW-1:0]  mem_wd;
    logic           mem_re;
    logic [LW-1:0]  mem_ra;
    logic [RW-1:0]  rd_q;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_q <= mem[mem_ra];
        end
    end

    // ------------------------------------------------------------------
    // Control and scalar state
    // ------------------------------------------------------------------
    logic [2:0]        state_reg, state_next;
    logic [LW-1:0]     sw_idx_reg, sw_idx_next;
    logic              wr_vld_reg, wr_vld_next;
    logic [LW-1:0]     wr_idx_reg, wr_idx_next;
    logic              clr_all_reg, clr_all_next;
    logic              clr_obs_reg, clr_obs_next;
    logic              clr_up_reg, clr_up_next;

    logic [LVL_W-1:0]  min_level_reg, min_level_next;
    logic [NB_W-1:0]   phase_reg, phase_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              obs_min_reg, obs_min_next;

    // latched item
    logic              op_reg, op_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic              chg_reg, chg_next;
    logic              le_mer_reg, le_mer_next;
    logic              gt_min_reg, gt_min_next;
    logic              mer_ok_reg, mer_ok_next;
    logic              bin_ok_reg, bin_ok_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [LVL_W-1:0]  o_min_reg, o_min_next;
    logic [OUT_W-1:0]  o_iter_reg, o_iter_next;
    logic [OUT_W-1:0]  o_vis_reg, o_vis_next;
    logic [OUT_W-1:0]  o_up_reg, o_up_next;
    logic [OUT_W-1:0]  o_all_reg, o_all_next;
    logic [OUT_W-1:0]  o_smp_reg, o_smp_next;
    logic              o_obs_reg, o_obs_next;

    // ------------------------------------------------------------------
    // Input decode: clip the level, work out which ranges a change clears
    // ------------------------------------------------------------------
    logic [XW-1:0] e_x, bin_x, mer_x, min_x;
    logic          e_big, bin_big;
    logic [LW-1:0] e_clip, bin_clip;
    logic          in_le_mer, in_gt_min, in_mer_ok, in_sweep;
    logic          s_fire, out_free;

    always_comb begin
        e_x       = XW'(s_energy);
        bin_x     = XW'(s_bin);
        mer_x     = XW'(mer_reg);
        min_x     = XW'(min_level_reg);
        e_big     = {1'b0, e_x} >= LEVELS_X;
        bin_big   = {1'b0, bin_x} >= LEVELS_X;
        e_clip    = e_big ? TOP_IDX : e_x[LW-1:0];
        bin_clip  = bin_big ? TOP_IDX : bin_x[LW-1:0];
        in_le_mer = XW'(e_clip) <= mer_x;
        in_gt_min = XW'(e_clip) > min_x;
        in_mer_ok = {1'b0, mer_x} < LEVELS_X;
        in_sweep  = (s_op == OP_RECORD) && s_changed && in_mer_ok && (in_le_mer || in_gt_min);
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Row update for the item in ST_UPD
    // ------------------------------------------------------------------
    logic [CB-1:0] r_vis, r_up, r_all, r_smp;
    logic          r_obs;
    logic [CB-1:0] n_vis, n_up, n_all, n_smp;
    logic          n_obs;
    logic          rec;
    logic [LVL_W-1:0] upd_min;
    logic          upd_obs_min;
    logic [NB_W:0] ph_inc;
    logic [NB_W:0] nb_eff;
    logic [NB_W-1:0] upd_phase;
    logic [ITER_W-1:0] upd_iter;

    always_comb begin
        r_vis = rd_q[VIS_LO +: CB];
        r_up  = rd_q[UP_LO  +: CB];
        r_all = rd_q[ALL_LO +: CB];
        r_smp = rd_q[SMP_LO +: CB];
        r_obs = rd_q[0];
        rec   = (op_reg == OP_RECORD);

        // mark an unobserved level above the max-entropy level
        n_obs = r_obs;
        n_smp = r_smp;
        if (chg_reg && !le_mer_reg && !r_obs) begin
            n_obs = 1'b1;
            n_smp = sat_inc(r_smp);
        end

        // track the highest level and the observed mark at it
        upd_min     = min_level_reg;
        upd_obs_min = obs_min_reg;
        if (chg_reg && gt_min_reg) begin
            upd_min     = LVL_W'(lvl_reg);
            upd_obs_min = n_obs;
        end else if (XW'(min_level_reg) == XW'(lvl_reg)) begin
            upd_obs_min = n_obs;
        end else if (chg_reg && le_mer_reg && mer_ok_reg && min_level_reg >= mer_reg) begin
            upd_obs_min = 1'b0;
        end

        // iteration phase
        nb_eff   = (nb_reg == '0) ? (NB_W + 1)'(1) : {1'b0, nb_reg};
        ph_inc   = {1'b0, phase_reg} + (NB_W + 1)'(1);
        upd_iter = iter_reg;
        if (ph_inc >= nb_eff) begin
            upd_phase = '0;
            upd_iter  = (iter_reg == {ITER_W{1'b1}}) ? iter_reg : iter_reg + ITER_W'(1);
        end else begin
            upd_phase = ph_inc[NB_W-1:0];
        end

        n_vis = sat_inc(r_vis);
        n_all = sat_inc(r_all);
        n_up  = upd_obs_min ? sat_inc(r_up) : r_up;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        sw_idx_next  = sw_idx_reg;
        wr_vld_next  = 1'b0;
        wr_idx_next  = sw_idx_reg;
        clr_all_next = clr_all_reg;
        clr_obs_next = clr_obs_reg;
        clr_up_next  = clr_up_reg;

        min_level_next = min_level_reg;
        phase_next     = phase_reg;
        iter_next      = iter_reg;
        obs_min_next   = obs_min_reg;

        op_next     = op_reg;
        lvl_next    = lvl_reg;
        chg_next    = chg_reg;
        le_mer_next = le_mer_reg;
        gt_min_next = gt_min_reg;
        mer_ok_next = mer_ok_reg;
        bin_ok_next = bin_ok_reg;

        m_valid_next = m_valid_reg && !m_ready;
        o_min_next   = o_min_reg;
        o_iter_next  = o_iter_reg;
        o_vis_next   = o_vis_reg;
        o_up_next    = o_up_reg;
        o_all_next   = o_all_reg;
        o_smp_next   = o_smp_reg;
        o_obs_next   = o_obs_reg;

        mem_re = 1'b0;
        mem_ra = lvl_reg;
        mem_we = 1'b0;
        mem_wa = wr_idx_reg;
        mem_wd = '0;

        // pending sweep write: drop the cleared fields of the row just read, or zero the whole row in the reset pass
        if (wr_vld_reg) begin
            mem_we = 1'b1;
            if (!clr_all_reg) begin
                mem_wd = rd_q;
                if (clr_up_reg) begin
                    mem_wd[UP_LO +: CB] = '0;
                end
                if (clr_obs_reg) begin
                    mem_wd[0] = 1'b0;
                end
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    mem_re      = 1'b1;
                    mem_ra      = (s_op == OP_READ) ? bin_clip : e_clip;
                    op_next     = s_op;
                    lvl_next    = mem_ra;
                    chg_next    = (s_op == OP_RECORD) && s_changed;
                    le_mer_next = in_le_mer;
                    gt_min_next = in_gt_min;
                    mer_ok_next = in_mer_ok;
                    bin_ok_next = !bin_big;
                    if (in_sweep) begin
                        clr_all_next = 1'b0;
                        clr_obs_next = in_le_mer;
                        clr_up_next  = in_gt_min;
                        sw_idx_next  = mer_x[LW-1:0];
                        state_next   = ST_SWEEP;
                    end else begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_SWEEP: begin
                // read one row per cycle, write it back the cycle after
                mem_re      = 1'b1;
                mem_ra      = sw_idx_reg;
                wr_vld_next = 1'b1;
                wr_idx_next = sw_idx_reg;
                if (sw_idx_reg == TOP_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    sw_idx_next = sw_idx_reg + LW'(1);
                end
            end
            ST_DRAIN: begin
                state_next   = clr_all_reg ? ST_IDLE : ST_RD;
                clr_all_next = 1'b0;
            end
            ST_RD: begin
                mem_re     = 1'b1;
                mem_ra     = lvl_reg;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (rec) begin
                        mem_we = 1'b1;
                        mem_wa = lvl_reg;
                        mem_wd = '0;
                        mem_wd[VIS_LO +: CB] = n_vis;
                        mem_wd[UP_LO  +: CB] = n_up;
                        mem_wd[ALL_LO +: CB] = n_all;
                        mem_wd[SMP_LO +: CB] = n_smp;
                        mem_wd[0]            = n_obs;
                        min_level_next = upd_min;
                        obs_min_next   = upd_obs_min;
                        phase_next     = upd_phase;
                        iter_next      = upd_iter;
                        o_min_next     = upd_min;
                        o_iter_next    = upd_iter;
                        o_vis_next     = clip_out(n_vis);
                        o_up_next      = clip_out(n_up);
                        o_all_next     = clip_out(n_all);
                        o_smp_next     = clip_out(n_smp);
                        o_obs_next     = n_obs;
                    end else begin
                        o_min_next  = min_level_reg;
                        o_iter_next = iter_reg;
                        o_vis_next  = bin_ok_reg ? clip_out(r_vis) : '0;
                        o_up_next   = bin_ok_reg ? clip_out(r_up)  : '0;
                        o_all_next  = bin_ok_reg ? clip_out(r_all) : '0;
                        o_smp_next  = bin_ok_reg ? clip_out(r_smp) : '0;
                        o_obs_next  = bin_ok_reg && r_obs;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // start with a clearing pass over the whole memory
            state_reg     <= ST_SWEEP;
            sw_idx_reg    <= '0;
            wr_vld_reg    <= 1'b0;
            clr_all_reg   <= 1'b1;
            clr_obs_reg   <= 1'b0;
            clr_up_reg    <= 1'b0;
            min_level_reg <= '0;
            phase_reg     <= '0;
            iter_reg      <= '0;
            obs_min_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sw_idx_reg    <= sw_idx_next;
            wr_vld_reg    <= wr_vld_next;
            clr_all_reg   <= clr_all_next;
            clr_obs_reg   <= clr_obs_next;
            clr_up_reg    <= clr_up_next;
            min_level_reg <= min_level_next;
            phase_reg     <= phase_next;
            iter_reg      <= iter_next;
            obs_min_reg   <= obs_min_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_idx_reg <= wr_idx_next;
        op_reg     <= op_next;
        lvl_reg    <= lvl_next;
        chg_reg    <= chg_next;
        le_mer_reg <= le_mer_next;
        gt_min_reg <= gt_min_next;
        mer_ok_reg <= mer_ok_next;
        bin_ok_reg <= bin_ok_next;
        o_min_reg  <= o_min_next;
        o_iter_reg <= o_iter_next;
        o_vis_reg  <= o_vis_next;
        o_up_reg   <= o_up_next;
        o_all_reg  <= o_all_next;
        o_smp_reg  <= o_smp_next;
        o_obs_reg  <= o_obs_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_min_energy_level = o_min_reg;
    assign m_iterations       = o_iter_reg;
    assign m_visit_count      = o_vis_reg;
    assign m_up_count         = o_up_reg;
    assign m_walker_count     = o_all_reg;
    assign m_sample_count     = o_smp_reg;
    assign m_observed_flag    = o_obs_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> !wr_vld_reg)
        else $error("sweep write overlaps item update");

    a_min_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> min_level_reg >= $past(min_level_reg))
        else $error("min energy level decreased");

    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == ST_UPD || state_reg == ST_SWEEP))
        else $error("accepted word not processed");

    a_result_after_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && out_free) |=> m_valid_reg)
        else $error("update did not load result");

endmodule
